// ----- rtl/core/cvfs_pkg.sv -----
package cvfs_pkg;

    // Defaults for the top-level parameters
    localparam int P_MAX_BEAMS    = 1024;
    localparam int P_CORDIC_STEPS = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_GAIN     = 3'd0,
        REG_FIELD_GAIN     = 3'd1,
        REG_LEVER_MM       = 3'd2,
        REG_INVERT_FORWARD = 3'd3,
        REG_INITIAL_SPLIT  = 3'd4,
        REG_FIRST_ANGLE    = 3'd5,
        REG_ANGLE_STEP     = 3'd6
    } t_reg_idx;

    // Fixed-point constants, angles in 2^-16 rad
    localparam int PI_Q16          = 205887;
    localparam int HALF_PI_Q16     = 102944;
    localparam int TWO_PI_Q16      = 411775;
    localparam int TWO_OVER_PI_Q16 = 41722;
    localparam int CORDIC_GAIN_Q16 = 39797;
    localparam int MIN_RANGE_MM    = 100;
    localparam int RANGE_NONE      = 65535;
    localparam int LEVER_SCALE     = 500;
    localparam int TURN_SCALE      = 1000;

    // Iteration counts of the shared units
    localparam int RED_STEPS  = 13;
    localparam int MUL_STEPS  = 17;
    localparam int SQRT_STEPS = 17;
    localparam int QUO_W      = 34;
    localparam int DIV_STEPS  = QUO_W;

    typedef struct packed {
        logic        operation;
        logic [15:0] range_mm;
        logic        last_in_scan;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] forward_speed;
        logic signed [23:0] turn_rate;
        logic               command_fresh;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_ALPHA,
        OP_RED_A,
        OP_ROT_A,
        OP_RED_D,
        OP_ROT_D,
        OP_MUL_NUM,
        OP_MUL_DEN,
        OP_VEC,
        OP_MUL_TH,
        OP_MUL_GG,
        OP_SQRT,
        OP_MUL_GCD,
        OP_MUL_HSD,
        OP_MUL_GSD,
        OP_MUL_HCD,
        OP_MUL_VX,
        OP_MUL_VY,
        OP_MUL_K,
        OP_DIV,
        OP_TURN
    } t_op;

    typedef struct packed {
        logic beam;
        logic tick_take;
        logic load;
        logic step;
        t_op  op;
        logic out_load;
        logic out_fresh;
    } t_cmd;

    typedef struct packed {
        logic fresh;
        logic out_free;
    } t_status;

    // Arctangent of 2^-k in 2^-16 rad
    function automatic logic [15:0] atan_entry(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Clamp to the 24-bit signed output range
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/corridor_vector_field_steering.sv -----
// Beam samples: one transaction per cycle while no tick is in work, no result, state updated in the accept cycle.
// Control tick with fresh scan data: the result is computed by the serial shift-add
// multiplier, the CORDIC, square-root and divider loops.
// Control tick without fresh data: stop command registered once the output register is free.
// No input is taken while a tick is in work; the output register frees the next tick.
// Synchronous active-low reset loads register defaults and clears scan state; no sweep.
module corridor_vector_field_steering
    import cvfs_pkg::*;
#(
    parameter int MAX_BEAMS    = P_MAX_BEAMS,
    parameter int CORDIC_STEPS = P_CORDIC_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    cvfs_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_operation(i_in_item.operation),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Scan tracking and steering arithmetic
    cvfs_datapath #(
        .MAX_BEAMS   (MAX_BEAMS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

// ----- rtl/core/cvfs_ctrl.sv -----
module cvfs_ctrl
    import cvfs_pkg::*;
#(
    parameter int CORDIC_STEPS = P_CORDIC_STEPS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    logic [5:0] r_cnt, n_cnt;
    logic       r_out_fresh, n_out_fresh;

    function automatic logic [5:0] op_steps(input t_op op);
        logic [5:0] s;
        case (op) inside
            OP_RED_A, OP_RED_D:         s = 6'(RED_STEPS);
            OP_ROT_A, OP_ROT_D, OP_VEC: s = 6'(CORDIC_STEPS);
            OP_SQRT:                    s = 6'(SQRT_STEPS);
            OP_DIV:                     s = 6'(DIV_STEPS);
            OP_MUL_NUM, OP_MUL_DEN, OP_MUL_TH, OP_MUL_GG, OP_MUL_GCD, OP_MUL_HSD,
            OP_MUL_GSD, OP_MUL_HCD, OP_MUL_VX, OP_MUL_VY, OP_MUL_K:
                                        s = 6'(MUL_STEPS);
            default:                    s = 6'd1;
        endcase
        return s;
    endfunction

    function automatic t_op next_op(input t_op op);
        t_op n;
        unique case (op)
            OP_ALPHA:   n = OP_RED_A;
            OP_RED_A:   n = OP_ROT_A;
            OP_ROT_A:   n = OP_RED_D;
            OP_RED_D:   n = OP_ROT_D;
            OP_ROT_D:   n = OP_MUL_NUM;
            OP_MUL_NUM: n = OP_MUL_DEN;
            OP_MUL_DEN: n = OP_VEC;
            OP_VEC:     n = OP_MUL_TH;
            OP_MUL_TH:  n = OP_MUL_GG;
            OP_MUL_GG:  n = OP_SQRT;
            OP_SQRT:    n = OP_MUL_GCD;
            OP_MUL_GCD: n = OP_MUL_HSD;
            OP_MUL_HSD: n = OP_MUL_GSD;
            OP_MUL_GSD: n = OP_MUL_HCD;
            OP_MUL_HCD: n = OP_MUL_VX;
            OP_MUL_VX:  n = OP_MUL_VY;
            OP_MUL_VY:  n = OP_MUL_K;
            OP_MUL_K:   n = OP_DIV;
            OP_DIV:     n = OP_TURN;
            default:    n = OP_TURN;
        endcase
        return n;
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_ALPHA;
            r_cnt       <= '0;
            r_out_fresh <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_out_fresh <= n_out_fresh;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_cnt           = r_cnt;
        n_out_fresh     = r_out_fresh;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.out_fresh = r_out_fresh;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (!i_operation) begin
                        o_cmd.beam = 1'b1;
                    end else if (i_status.fresh) begin
                        o_cmd.tick_take = 1'b1;
                        n_op            = OP_ALPHA;
                        n_out_fresh     = 1'b1;
                        n_state         = ST_LOAD;
                    end else begin
                        n_out_fresh = 1'b0;
                        n_state     = ST_OUT;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = op_steps(r_op);
                n_state    = ST_STEP;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    if (r_op == OP_TURN) begin
                        n_state = ST_OUT;
                    end else begin
                        n_op    = next_op(r_op);
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    ap_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_cnt != 6'd0))
        else $error("unit step issued with exhausted count");

    ap_fresh_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_operation && i_status.fresh)
        |=> (r_state == ST_LOAD && r_op == OP_ALPHA && r_out_fresh))
        else $error("fresh tick did not start the steering sequence");

    ap_stale_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_operation && !i_status.fresh)
        |=> (r_state == ST_OUT && !r_out_fresh))
        else $error("stale tick did not go straight to a stop command");

    ap_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a pending transaction");

endmodule

// ----- rtl/core/cvfs_datapath.sv -----
module cvfs_datapath
    import cvfs_pkg::*;
#(
    parameter int MAX_BEAMS    = P_MAX_BEAMS,
    parameter int CORDIC_STEPS = P_CORDIC_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    localparam int IW = $clog2(MAX_BEAMS + 1);
    localparam logic [IW-1:0] NO_INDEX = IW'(MAX_BEAMS);
    localparam logic [32:0] RED_OFFS = 33'(TWO_PI_Q16) << (RED_STEPS - 1);

    // Configuration registers
    logic [15:0]        r_speed_gain, r_field_gain, r_lever_mm, r_angle_step;
    logic               r_invert;
    logic [9:0]         r_initial_split;
    logic signed [18:0] r_first_angle;

    // Scan state
    logic [IW-1:0]      r_beam_cnt, r_split, r_ridx, r_lidx;
    logic [15:0]        r_rmin, r_lmin, r_rdist, r_ldist;
    logic signed [31:0] r_rang, r_lang;
    logic               r_fresh;

    // Scan update
    logic [IW-1:0]      b_cnt, b_ridx, b_lidx, b_mid;
    logic [15:0]        b_rmin, b_lmin;
    logic [IW:0]        b_sum;
    logic [IW+15:0]     b_prod_r, b_prod_l;
    logic signed [31:0] b_ang_r, b_ang_l;

    // Sequence registers
    logic [5:0]         r_it;
    logic signed [33:0] r_alpha, r_phid;
    logic [32:0]        r_u;
    logic signed [41:0] r_cx, r_cy, r_ynum;
    logic signed [19:0] r_cz;
    logic               r_neg, r_vec, r_tzero, r_nneg;
    logic signed [18:0] r_ca, r_cd, r_sd;
    logic signed [63:0] r_acc, r_mcand;
    logic [16:0]        r_mplier, r_h;
    logic signed [17:0] r_g;
    logic [32:0]        r_sv, r_sbit;
    logic [33:0]        r_sres;
    logic signed [37:0] r_vx, r_vy;
    logic signed [23:0] r_fwd, r_turn;
    logic [QUO_W-1:0]   r_quo;
    logic [15:0]        r_rem;
    logic               r_ovalid;
    t_out_item          r_out;

    // Combinational helpers
    logic signed [33:0] a_diff, a_alpha;
    logic [3:0]         red_k;
    logic [32:0]        red_m;
    logic signed [20:0] f_r;
    logic               f_neg;
    logic [4:0]         c_k;
    logic signed [41:0] c_xs, c_ys, c_x, c_y, c_x0, c_y0;
    logic signed [19:0] c_tab, c_z;
    logic               c_pos;
    logic signed [16:0] d_diff;
    logic signed [63:0] g_t, fwd_t, turn_t, n_mag;
    logic signed [17:0] g_new;
    logic [16:0]        g_mag_new, g_mag;
    logic [33:0]        s_sum;
    logic [15:0]        lever_d;
    logic [63:0]        dv_num;
    logic [16:0]        dv_t;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain    <= 16'd256;
            r_field_gain    <= 16'd256;
            r_lever_mm      <= 16'd200;
            r_invert        <= 1'b0;
            r_initial_split <= 10'd120;
            r_first_angle   <= -19'sd205887;
            r_angle_step    <= 16'd402;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SPEED_GAIN:     r_speed_gain    <= i_cfg_data[15:0];
                REG_FIELD_GAIN:     r_field_gain    <= i_cfg_data[15:0];
                REG_LEVER_MM:       r_lever_mm      <= i_cfg_data[15:0];
                REG_INVERT_FORWARD: r_invert        <= i_cfg_data[0];
                REG_INITIAL_SPLIT:  r_initial_split <= i_cfg_data[9:0];
                REG_FIRST_ANGLE:    r_first_angle   <= $signed(i_cfg_data[18:0]);
                REG_ANGLE_STEP:     r_angle_step    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Track nearest return on each side of the split
    always_comb begin
        b_cnt  = r_beam_cnt;
        b_rmin = r_rmin;
        b_ridx = r_ridx;
        b_lmin = r_lmin;
        b_lidx = r_lidx;
        if (r_beam_cnt < NO_INDEX) begin
            if (r_beam_cnt < r_split) begin
                if (i_in_item.range_mm > 16'(MIN_RANGE_MM) && i_in_item.range_mm < r_rmin) begin
                    b_rmin = i_in_item.range_mm;
                    b_ridx = r_beam_cnt;
                end
            end else if (i_in_item.range_mm > 16'(MIN_RANGE_MM)
                         && i_in_item.range_mm < r_lmin) begin
                b_lmin = i_in_item.range_mm;
                b_lidx = r_beam_cnt;
            end
            b_cnt = r_beam_cnt + IW'(1);
        end
        b_sum    = {1'b0, b_ridx} + {1'b0, b_lidx};
        b_mid    = b_sum[IW:1];
        b_prod_r = b_ridx * r_angle_step;
        b_prod_l = b_lidx * r_angle_step;
        b_ang_r  = 32'(r_first_angle) + $signed(32'(b_prod_r));
        b_ang_l  = 32'(r_first_angle) + $signed(32'(b_prod_l));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_cnt <= '0;
            r_split    <= IW'(10'd120);
            r_rmin     <= 16'(RANGE_NONE);
            r_ridx     <= NO_INDEX;
            r_lmin     <= 16'(RANGE_NONE);
            r_lidx     <= NO_INDEX;
            r_rdist    <= 16'(RANGE_NONE);
            r_ldist    <= 16'(RANGE_NONE);
            r_rang     <= '0;
            r_lang     <= '0;
            r_fresh    <= 1'b0;
        end else begin
            if (i_cfg_we && t_reg_idx'(i_cfg_index) == REG_INITIAL_SPLIT) begin
                r_split <= IW'(i_cfg_data[9:0]);
            end
            if (i_cmd.tick_take) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.beam) begin
                if (i_in_item.last_in_scan) begin
                    // Close the scan: latch distances, re-center when both sides hit
                    r_rdist    <= b_rmin;
                    r_ldist    <= b_lmin;
                    if (b_ridx != NO_INDEX && b_lidx != NO_INDEX) begin
                        r_split <= b_mid;
                        r_rang  <= b_ang_r;
                        r_lang  <= b_ang_l;
                        r_fresh <= 1'b1;
                    end
                    r_beam_cnt <= '0;
                    r_rmin     <= 16'(RANGE_NONE);
                    r_ridx     <= NO_INDEX;
                    r_lmin     <= 16'(RANGE_NONE);
                    r_lidx     <= NO_INDEX;
                end else begin
                    r_beam_cnt <= b_cnt;
                    r_rmin     <= b_rmin;
                    r_ridx     <= b_ridx;
                    r_lmin     <= b_lmin;
                    r_lidx     <= b_lidx;
                end
            end
        end
    end

    // Shared-unit helpers
    always_comb begin
        a_diff  = 34'(r_lang) - 34'(r_rang) - 34'(PI_Q16);
        a_alpha = a_diff >>> 1;

        red_k = 4'(6'(RED_STEPS - 1) - r_it);
        red_m = 33'(TWO_PI_Q16) << red_k;

        // Fold the reduced angle into [-pi/2, pi/2]
        f_r   = $signed({2'b00, r_u[18:0]});
        f_neg = 1'b0;
        if (f_r > 21'(PI_Q16)) begin
            f_r = f_r - 21'(TWO_PI_Q16);
        end
        if (f_r > 21'(HALF_PI_Q16)) begin
            f_r   = f_r - 21'(PI_Q16);
            f_neg = 1'b1;
        end else if (f_r < -21'(HALF_PI_Q16)) begin
            f_r   = f_r + 21'(PI_Q16);
            f_neg = 1'b1;
        end

        // One CORDIC micro-rotation
        c_k   = r_it[4:0];
        c_xs  = r_cx >>> c_k;
        c_ys  = r_cy >>> c_k;
        c_tab = $signed({4'b0000, atan_entry(c_k)});
        c_pos = r_vec ? r_cy[41] : !r_cz[19];
        if (c_pos) begin
            c_x = r_cx - c_ys;
            c_y = r_cy + c_xs;
            c_z = r_cz - c_tab;
        end else begin
            c_x = r_cx + c_ys;
            c_y = r_cy - c_xs;
            c_z = r_cz + c_tab;
        end

        c_x0 = 42'(r_acc);
        c_y0 = r_ynum;
        if (c_x0 < 0) begin
            c_x0 = -c_x0;
            c_y0 = -c_y0;
        end

        d_diff = $signed({1'b0, r_ldist}) - $signed({1'b0, r_rdist});

        g_t = -((r_acc + 64'sd32768) >>> 16);
        if (g_t > 64'sd65536) begin
            g_new = 18'sd65536;
        end else if (g_t < -64'sd65536) begin
            g_new = -18'sd65536;
        end else begin
            g_new = g_t[17:0];
        end
        g_mag_new = g_new[17] ? 17'(-g_new) : 17'(g_new);
        g_mag     = r_g[17] ? 17'(-r_g) : 17'(r_g);

        s_sum = r_sres + {1'b0, r_sbit};

        fwd_t = (r_acc + (64'sd1 <<< 27)) >>> 28;
        if (r_invert) begin
            fwd_t = -fwd_t;
        end

        lever_d = (r_lever_mm == 16'd0) ? 16'd1 : r_lever_mm;
        n_mag   = r_acc[63] ? -r_acc : r_acc;
        dv_num  = (64'(n_mag) + (64'(lever_d) << 27)) >> 28;
        dv_t    = {r_rem, r_quo[QUO_W-1]};

        turn_t = r_nneg ? -$signed(64'(r_quo)) : $signed(64'(r_quo));
    end

    // Steering sequence: load one operation, then iterate its unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it <= '0;
            case (i_cmd.op) inside
                OP_ALPHA: begin
                    r_alpha <= a_alpha;
                    r_phid  <= 34'(r_rang) + a_alpha;
                end
                OP_RED_A: r_u <= 33'(35'(r_alpha) + 35'(RED_OFFS));
                OP_RED_D: begin
                    r_ca <= 19'(r_neg ? -r_cx : r_cx);
                    r_u  <= 33'(35'(r_phid) + 35'(RED_OFFS));
                end
                OP_ROT_A, OP_ROT_D: begin
                    r_cx  <= 42'(CORDIC_GAIN_Q16);
                    r_cy  <= '0;
                    r_cz  <= 20'(f_r);
                    r_neg <= f_neg;
                    r_vec <= 1'b0;
                end
                OP_MUL_NUM: begin
                    r_cd     <= 19'(r_neg ? -r_cx : r_cx);
                    r_sd     <= 19'(r_neg ? -r_cy : r_cy);
                    r_acc    <= '0;
                    r_mcand  <= 64'(d_diff);
                    r_mplier <= 17'(r_field_gain);
                end
                OP_MUL_DEN: begin
                    r_ynum   <= 42'(r_acc <<< 6);
                    r_acc    <= '0;
                    r_mcand  <= 64'(r_ca);
                    r_mplier <= 17'(LEVER_SCALE);
                end
                OP_VEC: begin
                    r_cx    <= c_x0;
                    r_cy    <= c_y0;
                    r_cz    <= '0;
                    r_tzero <= (c_x0 == 0) && (c_y0 == 0);
                    r_vec   <= 1'b1;
                end
                OP_MUL_TH: begin
                    r_acc    <= '0;
                    r_mcand  <= r_tzero ? 64'sd0 : 64'(r_cz);
                    r_mplier <= 17'(TWO_OVER_PI_Q16);
                end
                OP_MUL_GG: begin
                    r_g      <= g_new;
                    r_acc    <= '0;
                    r_mcand  <= $signed(64'(g_mag_new));
                    r_mplier <= g_mag_new;
                end
                OP_SQRT: begin
                    r_sv   <= (33'd1 << 32) - r_acc[32:0];
                    r_sres <= '0;
                    r_sbit <= 33'd1 << 32;
                end
                OP_MUL_GCD: begin
                    r_h      <= r_sres[16:0];
                    r_acc    <= '0;
                    r_mcand  <= r_g[17] ? -64'(r_cd) : 64'(r_cd);
                    r_mplier <= g_mag;
                end
                OP_MUL_HSD: begin
                    r_mcand  <= -64'(r_sd);
                    r_mplier <= r_h;
                end
                OP_MUL_GSD: begin
                    r_vx     <= r_acc[37:0];
                    r_acc    <= '0;
                    r_mcand  <= r_g[17] ? -64'(r_sd) : 64'(r_sd);
                    r_mplier <= g_mag;
                end
                OP_MUL_HCD: begin
                    r_mcand  <= 64'(r_cd);
                    r_mplier <= r_h;
                end
                OP_MUL_VX: begin
                    r_vy     <= r_acc[37:0];
                    r_acc    <= '0;
                    r_mcand  <= 64'(r_vx);
                    r_mplier <= 17'(r_speed_gain);
                end
                OP_MUL_VY: begin
                    r_fwd    <= sat24(fwd_t);
                    r_acc    <= '0;
                    r_mcand  <= 64'(r_vy);
                    r_mplier <= 17'(r_speed_gain);
                end
                OP_MUL_K: begin
                    r_acc    <= '0;
                    r_mcand  <= r_acc;
                    r_mplier <= 17'(TURN_SCALE);
                end
                OP_DIV: begin
                    r_nneg <= r_acc[63];
                    r_quo  <= dv_num[QUO_W-1:0];
                    r_rem  <= '0;
                end
                OP_TURN: r_turn <= sat24(turn_t);
                default: ;
            endcase
        end else if (i_cmd.step) begin
            r_it <= r_it + 6'd1;
            case (i_cmd.op) inside
                OP_RED_A, OP_RED_D: begin
                    if (r_u >= red_m) begin
                        r_u <= r_u - red_m;
                    end
                end
                OP_ROT_A, OP_ROT_D, OP_VEC: begin
                    r_cx <= c_x;
                    r_cy <= c_y;
                    r_cz <= c_z;
                end
                OP_SQRT: begin
                    if ({1'b0, r_sv} >= s_sum) begin
                        r_sv   <= 33'({1'b0, r_sv} - s_sum);
                        r_sres <= (r_sres >> 1) + {1'b0, r_sbit};
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
                OP_DIV: begin
                    if (dv_t >= {1'b0, lever_d}) begin
                        r_rem <= 16'(dv_t - {1'b0, lever_d});
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= dv_t[15:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                end
                OP_MUL_NUM, OP_MUL_DEN, OP_MUL_TH, OP_MUL_GG, OP_MUL_GCD, OP_MUL_HSD,
                OP_MUL_GSD, OP_MUL_HCD, OP_MUL_VX, OP_MUL_VY, OP_MUL_K: begin
                    // Shift-add: one multiplier bit per cycle
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_fresh) begin
                r_out.forward_speed <= r_fwd;
                r_out.turn_rate     <= r_turn;
                r_out.command_fresh <= 1'b1;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_status.fresh    = r_fresh;
    assign o_status.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid       = r_ovalid;
    assign o_out_item        = r_out;

endmodule

// ----- tb/tb_corridor_vector_field_steering.sv -----
`timescale 1ns / 100ps

module tb_corridor_vector_field_steering;
    import cvfs_pkg::*;

    localparam int  BEAM_LIMIT   = 1024;
    localparam int  ROT_STEPS    = 16;
    localparam int  SPLIT_NONE   = BEAM_LIMIT;
    localparam longint CYCLE_CAP = 3000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    corridor_vector_field_steering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration
    int unsigned kv_speed, kv_field, kv_lever, kv_invert, kv_split0, kv_step;
    int          kv_first;

    // Predictor copy of the scan and steering state
    int unsigned scan_pos, split_at;
    int unsigned near_r, near_r_idx, near_l, near_l_idx;
    int unsigned dist_r, dist_l;
    int          ang_r, ang_l;
    bit          have_fix;

    t_out_item   cmd_q[$];
    int          err_count;
    longint      cycle_count;
    bit          quiet;
    int          n_beams, n_ticks, n_fresh, n_cmds;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } dir_row_t;

    localparam t_out_item STOP_CMD = '{24'sd0, 24'sd0, 1'b0};
    localparam t_out_item ANY_CMD  = '{24'sd0, 24'sd0, 1'b0};

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint atan_step(int k);
        longint tab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (k < 17) ? tab[k] : 0;
    endfunction

    // Rotation CORDIC after folding the angle into [-pi/2, pi/2]
    function automatic void rot_cordic(longint a, output longint c, output longint s);
        longint r, x, y, t;
        bit     flip;
        r = a % TWO_PI_Q16;
        x = CORDIC_GAIN_Q16;
        y = 0;
        flip = 1'b0;
        if (r < 0) r += TWO_PI_Q16;
        if (r > PI_Q16) r -= TWO_PI_Q16;
        if (r > HALF_PI_Q16) begin
            r -= PI_Q16;
            flip = 1'b1;
        end else if (r < -HALF_PI_Q16) begin
            r += PI_Q16;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (r >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); r -= atan_step(i);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); r += atan_step(i);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Vectoring CORDIC: angle of (x, y)
    function automatic longint vec_cordic(longint y, longint x);
        longint z, t;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (y < 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Steering command from the latched scan
    function automatic t_out_item steer_command();
        longint alpha, phid, ca, sa, cd, sd, theta, g, h, vx, vy, v, w, d, num, mag, q;
        t_out_item o;
        alpha = (longint'(ang_l) - longint'(ang_r) - PI_Q16) >>> 1;
        phid  = longint'(ang_r) + alpha;
        rot_cordic(alpha, ca, sa);
        rot_cordic(phid, cd, sd);
        theta = vec_cordic(longint'(kv_field) * (longint'(dist_l) - longint'(dist_r)) * 64,
                           ca * LEVER_SCALE);
        g = -((theta * TWO_OVER_PI_Q16 + (64'sd1 <<< 15)) >>> 16);
        if (g > 65536) g = 65536;
        if (g < -65536) g = -65536;
        h = longint'(int_sqrt(longint'(64'sd1 <<< 32) - g * g));
        vx = g * cd - h * sd;
        vy = g * sd + h * cd;
        v = (longint'(kv_speed) * vx + (64'sd1 <<< 27)) >>> 28;
        if (kv_invert != 0) v = -v;
        v = clamp24(v);
        d = (kv_lever == 0) ? 1 : longint'(kv_lever);
        num = longint'(kv_speed) * vy * TURN_SCALE;
        mag = (num < 0) ? -num : num;
        d = d <<< 28;
        q = (mag + d / 2) / d;
        w = clamp24((num < 0) ? -q : q);
        o.forward_speed = v[23:0];
        o.turn_rate     = w[23:0];
        o.command_fresh = 1'b1;
        return o;
    endfunction

    // Advance the predictor by one accepted transaction
    function automatic bit advance(t_in_item it, output t_out_item o);
        o = STOP_CMD;
        if (it.operation == 1'b0) begin
            n_beams++;
            if (scan_pos < BEAM_LIMIT) begin
                if (scan_pos < split_at) begin
                    if (it.range_mm > MIN_RANGE_MM && it.range_mm < near_r) begin
                        near_r = it.range_mm;
                        near_r_idx = scan_pos;
                    end
                end else if (it.range_mm > MIN_RANGE_MM && it.range_mm < near_l) begin
                    near_l = it.range_mm;
                    near_l_idx = scan_pos;
                end
                scan_pos++;
            end
            if (it.last_in_scan) begin
                dist_r = near_r;
                dist_l = near_l;
                if (near_r_idx != SPLIT_NONE && near_l_idx != SPLIT_NONE) begin
                    split_at = (near_r_idx + near_l_idx) / 2;
                    ang_r = kv_first + int'(near_r_idx * kv_step);
                    ang_l = kv_first + int'(near_l_idx * kv_step);
                    have_fix = 1'b1;
                end
                near_r = RANGE_NONE; near_r_idx = SPLIT_NONE;
                near_l = RANGE_NONE; near_l_idx = SPLIT_NONE;
                scan_pos = 0;
            end
            return 1'b0;
        end
        n_ticks++;
        if (have_fix) begin
            have_fix = 1'b0;
            n_fresh++;
            o = steer_command();
        end
        return 1'b1;
    endfunction

    // Send one transaction, with an optional gap before it
    task automatic send(t_in_item it, bit typed = 1'b0, t_out_item want = ANY_CMD);
        t_out_item o;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (advance(it, o)) cmd_q.push_back(typed ? want : o);
        @(negedge i_clk);
    endtask

    // Write all registers while the block is idle
    task automatic load_regs(int sp, int fg, int lv, int inv, int spl, int fa, int st);
        int vals[7] = '{sp, fg, lv, inv, spl, fa, st};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= vals[i][CFG_DATA_W-1:0];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        kv_speed  = sp[15:0];
        kv_field  = fg[15:0];
        kv_lever  = lv[15:0];
        kv_invert = inv & 1;
        kv_split0 = spl[9:0];
        split_at  = kv_split0;
        kv_first  = fa;
        kv_step   = st[15:0];
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (cmd_q.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_in_item beam(int unsigned r, bit last);
        t_in_item it;
        it.operation = 1'b0;
        it.range_mm = r[15:0];
        it.last_in_scan = last;
        return it;
    endfunction

    function automatic int unsigned pick_range();
        case ($urandom_range(0, 5))
            0:       return RANGE_NONE;
            1:       return $urandom_range(0, MIN_RANGE_MM);
            2:       return $urandom_range(MIN_RANGE_MM + 1, 3000);
            default: return $urandom & 16'hFFFF;
        endcase
    endfunction

    // Output side stall bursts
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmd_q.size() == 0) begin
                $error("unexpected result transaction");
                err_count++;
            end else begin
                e = cmd_q.pop_front();
                n_cmds++;
                if (o_out_item.forward_speed !== e.forward_speed) begin
                    $error("forward_speed expected %0d got %0d",
                           e.forward_speed, o_out_item.forward_speed);
                    err_count++;
                end
                if (o_out_item.turn_rate !== e.turn_rate) begin
                    $error("turn_rate expected %0d got %0d", e.turn_rate, o_out_item.turn_rate);
                    err_count++;
                end
                if (o_out_item.command_fresh !== e.command_fresh) begin
                    $error("command_fresh expected %0d got %0d",
                           e.command_fresh, o_out_item.command_fresh);
                    err_count++;
                end
            end
        end
    end

    localparam t_in_item TICK = '{1'b1, 16'd0, 1'b0};

    dir_row_t dir_rows[17] = '{
        '{TICK,                        1'b1, STOP_CMD},
        '{'{1'b0, 16'd0, 1'b0},        1'b0, ANY_CMD},
        '{'{1'b0, 16'd100, 1'b0},      1'b0, ANY_CMD},
        '{'{1'b0, 16'd65535, 1'b0},    1'b0, ANY_CMD},
        '{'{1'b0, 16'd101, 1'b1},      1'b0, ANY_CMD},
        '{TICK,                        1'b1, STOP_CMD},
        '{'{1'b0, 16'd101, 1'b0},      1'b0, ANY_CMD},
        '{'{1'b0, 16'd300, 1'b0},      1'b0, ANY_CMD},
        '{'{1'b0, 16'd65535, 1'b0},    1'b0, ANY_CMD},
        '{'{1'b0, 16'd400, 1'b1},      1'b0, ANY_CMD},
        '{'{1'b1, 16'hFFFF, 1'b1},     1'b0, ANY_CMD},
        '{TICK,                        1'b1, STOP_CMD},
        '{'{1'b0, 16'd5000, 1'b0},     1'b0, ANY_CMD},
        '{'{1'b0, 16'd200, 1'b1},      1'b0, ANY_CMD},
        '{TICK,                        1'b0, ANY_CMD},
        '{'{1'b0, 16'hAAAA, 1'b0},     1'b0, ANY_CMD},
        '{'{1'b0, 16'h5555, 1'b1},     1'b0, ANY_CMD}
    };

    // Stimulus
    initial begin
        int nb, spl;
        t_in_item tk;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cycle_count = 0;
        err_count = 0;
        quiet = 1'b0;
        stall_left = 0;
        n_beams = 0; n_ticks = 0; n_fresh = 0; n_cmds = 0;
        kv_speed = 256; kv_field = 256; kv_lever = 200; kv_invert = 0;
        kv_split0 = 120; kv_first = -205887; kv_step = 402;
        scan_pos = 0; split_at = kv_split0;
        near_r = RANGE_NONE; near_r_idx = SPLIT_NONE;
        near_l = RANGE_NONE; near_l_idx = SPLIT_NONE;
        dist_r = RANGE_NONE; dist_l = RANGE_NONE;
        ang_r = 0; ang_l = 0; have_fix = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tiny split so both sides fill in a few beams
        load_regs(256, 256, 200, 0, 2, -205887, 402);
        foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Random phases, each with its own register setting
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: load_regs(65535, 65535, 0, 1, 0, -262144, 65535);
                1: load_regs(0, 0, 65535, 0, 1023, 262143, 0);
                2: load_regs(256, 256, 1, 1, 5, -205887, 0);
                default: load_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 1),
                                   $urandom_range(0, 30), $urandom_range(0, 524287) - 262144,
                                   $urandom_range(0, 65535));
            endcase
            quiet = (p == 6);
            // One over-long scan runs past the beam limit
            if (p == 3) begin
                for (int b = 0; b < BEAM_LIMIT + 6; b++)
                    send(beam(pick_range(), b == BEAM_LIMIT + 5));
                tk = TICK;
                send(tk);
            end
            for (int s = 0; s < 10; s++) begin
                nb = (s == 0 && p == 1) ? 1 : $urandom_range(1, 24);
                for (int b = 0; b < nb; b++) send(beam(pick_range(), b == nb - 1));
                repeat ($urandom_range(0, 2)) begin
                    tk = TICK;
                    tk.range_mm = $urandom & 16'hFFFF;
                    tk.last_in_scan = $urandom_range(0, 1);
                    send(tk);
                end
            end
            drain();
        end

        i_in_valid <= 1'b0;
        wait (cmd_q.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Run covered %0d beam and %0d tick transactions over eight register settings,",
                 n_beams, n_ticks);
        $display("with %0d computed commands among %0d checked results.", n_fresh, n_cmds);
        if (err_count == 0 && cmd_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
